### hw/rtl/bpsae_pkg.sv
// Package for the binary property list string array extractor.
// Holds the parse phase type, result entry type, magic table and UTF-8 encoder.
// No dependencies.
`timescale 1ns / 1ps

package bpsae_pkg;

  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned RES_MAX    = 5;
  localparam int unsigned RES_W      = $clog2(RES_MAX + 1);
  localparam int unsigned LEN_W      = 16;

  localparam logic [7:0] NL_BYTE   = 8'h0A;
  localparam logic [15:0] NL_UNIT  = 16'h000A;
  localparam logic [3:0] ARRAY_NIB = 4'hA;
  localparam logic [3:0] EXT_NIB   = 4'hF;
  localparam logic [3:0] INT_NIB   = 4'h1;
  localparam logic [3:0] ASCII_NIB = 4'h5;
  localparam logic [3:0] UTF16_NIB = 4'h6;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_ARRAY,
    PH_ALEN_MARK,
    PH_ALEN_BYTES,
    PH_REFS,
    PH_SMARK,
    PH_SLEN_MARK,
    PH_SLEN_BYTES,
    PH_UNITS,
    PH_SKIP,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ERR_MAGIC     = 3'd0,
    ERR_ARRAY     = 3'd1,
    ERR_ARRAY_LEN = 3'd2,
    ERR_STR_MARK  = 3'd3,
    ERR_STR_LEN   = 3'd4,
    ERR_SURROGATE = 3'd5
  } err_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_err;
    logic [2:0] code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } utf8_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = 8'h62;
      3'd1:    b = 8'h70;
      3'd2:    b = 8'h6C;
      3'd3:    b = 8'h69;
      3'd4:    b = 8'h73;
      3'd5:    b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.bytes[0] = cp[7:0];
      r.n = 3'd1;
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.n = 3'd2;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.n = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.n = 3'd4;
    end
    return r;
  endfunction

endpackage

### hw/rtl/bplist_string_array_extractor_unit.sv
// Binary property list string array extractor, top level.
// The first result of a transfer is registered and presented in the cycle after it.
// One input per cycle while each yields at most one result and m_axis_tready is high;
// after an input that yields more results, the next is taken only as the last is drained.
// Reset: asynchronous, active low; parse state cleared, strip_trailer_enable = 1.
// Depends on bpsae_pkg.
`timescale 1ns / 1ps

module bplist_string_array_extractor_unit
  import bpsae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic        cfg_wdata_i,   // strip_trailer_enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tuser,  // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [10:8] error_code, zero pad
  output logic        m_axis_tuser,  // [0] is_error
  output logic        m_axis_tlast   // last
);

  logic strip_en_q;

  phase_e                phase_q, phase_d;
  logic [2:0]            pos_q, pos_d;
  logic [COUNT_BITS-1:0] strings_q, strings_d;
  logic [COUNT_BITS-1:0] units_q, units_d;
  logic [LEN_W-1:0]      len_left_q, len_left_d;
  logic [COUNT_BITS-1:0] acc_q, acc_d;
  logic                  wide_q, wide_d;
  logic [7:0]            hi_q, hi_d;
  logic [9:0]            pend_q, pend_d;
  logic                  pend_v_q, pend_v_d;
  logic                  halted_q, halted_d;

  res_t             buf_q [RES_MAX];
  res_t             res_d [RES_MAX];
  logic [RES_W-1:0] cnt_q, rd_q, nres;

  logic s_xfer, m_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == RES_W'(1)) && m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_en_q <= 1'b1;
    end else if (cfg_wen_i) begin
      strip_en_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    phase_e                c_phase;
    logic [2:0]            c_pos;
    logic [COUNT_BITS-1:0] c_strings, c_units, c_acc, n_len, acc_new, units_dec;
    logic [LEN_W-1:0]      c_len;
    logic                  c_wide, c_pend_v, c_halted;
    logic [7:0]            b;
    logic [3:0]            hn, ln;
    logic [15:0]           u;
    logic                  err, nl, end_str, len_known, strip, lo_sur, hi_sur;
    logic [2:0]            code;
    utf8_t                 txt;
    b  = s_axis_tdata;
    hn = b[7:4];
    ln = b[3:0];
    if (s_axis_tuser) begin
      c_phase = PH_MAGIC; c_pos = '0; c_strings = '0; c_units = '0; c_len = '0;
      c_acc = '0; c_wide = 1'b0; c_pend_v = 1'b0; c_halted = 1'b0;
      hi_d = '0; pend_d = '0;
    end else begin
      c_phase = phase_q; c_pos = pos_q; c_strings = strings_q; c_units = units_q;
      c_len = len_left_q; c_acc = acc_q; c_wide = wide_q; c_pend_v = pend_v_q;
      c_halted = halted_q; hi_d = hi_q; pend_d = pend_q;
    end
    phase_d = c_phase; pos_d = c_pos; strings_d = c_strings; units_d = c_units;
    len_left_d = c_len; acc_d = c_acc; wide_d = c_wide; pend_v_d = c_pend_v;
    halted_d = c_halted;
    err = 1'b0; code = ERR_MAGIC; end_str = 1'b0; len_known = 1'b0;
    n_len = {{(COUNT_BITS-4){1'b0}}, ln};
    txt = '0;
    units_dec = c_units - COUNT_BITS'(1);
    acc_new = {c_acc[COUNT_BITS-9:0], b};
    u = {hi_d, b};
    strip = 1'b0; lo_sur = 1'b0; hi_sur = 1'b0;

    if (!c_halted) begin
      unique case (c_phase)
        PH_MAGIC: begin
          if (c_pos < 3'd6 && b != magic_byte(c_pos)) begin
            err = 1'b1; code = ERR_MAGIC;
          end else if (c_pos == 3'd7) begin
            pos_d = '0; phase_d = PH_ARRAY;
          end else begin
            pos_d = c_pos + 3'd1;
          end
        end
        PH_ARRAY: begin
          if (hn != ARRAY_NIB) begin
            err = 1'b1; code = ERR_ARRAY;
          end else if (ln == EXT_NIB) begin
            phase_d = PH_ALEN_MARK;
          end else begin
            strings_d = n_len; units_d = n_len;
            phase_d = (ln == 4'd0) ? PH_DONE : PH_REFS;
          end
        end
        PH_ALEN_MARK, PH_SLEN_MARK: begin
          if (hn != INT_NIB) begin
            err = 1'b1;
            code = (c_phase == PH_ALEN_MARK) ? ERR_ARRAY_LEN : ERR_STR_LEN;
          end else begin
            len_left_d = LEN_W'(1) << ln;
            acc_d = '0;
            phase_d = (c_phase == PH_ALEN_MARK) ? PH_ALEN_BYTES : PH_SLEN_BYTES;
          end
        end
        PH_ALEN_BYTES, PH_SLEN_BYTES: begin
          acc_d = acc_new;
          len_left_d = c_len - LEN_W'(1);
          if (c_len == LEN_W'(1)) begin
            if (c_phase == PH_ALEN_BYTES) begin
              strings_d = acc_new; units_d = acc_new;
              phase_d = (acc_new == '0) ? PH_DONE : PH_REFS;
            end else begin
              len_known = 1'b1; n_len = acc_new;
            end
          end
        end
        PH_REFS: begin
          units_d = units_dec;
          if (units_dec == '0) phase_d = PH_SMARK;
        end
        PH_SMARK: begin
          if (hn != ASCII_NIB && hn != UTF16_NIB) begin
            err = 1'b1; code = ERR_STR_MARK;
          end else begin
            wide_d = (hn == UTF16_NIB);
            if (ln == EXT_NIB) phase_d = PH_SLEN_MARK;
            else len_known = 1'b1;
          end
        end
        PH_UNITS: begin
          if (!c_wide) begin
            if (strip_en_q && c_units == COUNT_BITS'(2) && b == NL_BYTE) begin
              phase_d = PH_SKIP; pos_d = '0;
            end else begin
              txt.bytes[0] = b; txt.n = 3'd1;
              units_d = units_dec;
              end_str = (units_dec == '0);
            end
          end else if (!c_pos[0]) begin
            hi_d = b; pos_d = 3'd1;
          end else begin
            pos_d = '0;
            strip = strip_en_q && c_units == COUNT_BITS'(2) && u == NL_UNIT;
            lo_sur = (u >= 16'hDC00) && (u <= 16'hDFFF);
            hi_sur = (u >= 16'hD800) && (u <= 16'hDBFF);
            if (c_pend_v) begin
              if (!lo_sur) begin
                err = 1'b1; code = ERR_SURROGATE;
              end else begin
                pend_v_d = 1'b0;
                txt = utf8_encode(21'h10000 + {1'b0, pend_d, u[9:0]});
                units_d = units_dec; end_str = (units_dec == '0);
              end
            end else if (hi_sur) begin
              if (c_units == COUNT_BITS'(1)) begin
                err = 1'b1; code = ERR_SURROGATE;
              end else begin
                pend_d = u[9:0]; pend_v_d = 1'b1;
                units_d = units_dec;
              end
            end else if (lo_sur) begin
              err = 1'b1; code = ERR_SURROGATE;
            end else if (strip) begin
              phase_d = PH_SKIP;
            end else begin
              txt = utf8_encode({5'b0, u});
              units_d = units_dec; end_str = (units_dec == '0);
            end
          end
        end
        PH_SKIP: begin
          if (c_wide && c_pos == '0) begin
            pos_d = 3'd1;
          end else begin
            pos_d = '0; end_str = 1'b1;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end

    if (len_known) begin
      units_d = n_len; pos_d = '0; pend_v_d = 1'b0;
      if (n_len == '0) end_str = 1'b1;
      else phase_d = PH_UNITS;
    end
    nl = end_str;
    if (end_str) begin
      strings_d = c_strings - COUNT_BITS'(1);
      phase_d = (c_strings == COUNT_BITS'(1)) ? PH_DONE : PH_SMARK;
    end
    if (err) begin
      halted_d = 1'b1;
      nres = RES_W'(1);
    end else begin
      nres = RES_W'(txt.n) + RES_W'(nl);
    end
    for (int i = 0; i < RES_MAX; i++) begin
      res_d[i].is_err = err;
      res_d[i].code   = err ? code : ERR_MAGIC;
      res_d[i].data   = err ? 8'h00 :
                        (RES_W'(i) < RES_W'(txt.n)) ? txt.bytes[i[1:0]] : NL_BYTE;
      res_d[i].last   = (RES_W'(i) == nres - RES_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      pos_q      <= '0;
      strings_q  <= '0;
      units_q    <= '0;
      len_left_q <= '0;
      acc_q      <= '0;
      wide_q     <= 1'b0;
      hi_q       <= '0;
      pend_q     <= '0;
      pend_v_q   <= 1'b0;
      halted_q   <= 1'b0;
      cnt_q      <= '0;
      rd_q       <= '0;
    end else if (s_xfer) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      strings_q  <= strings_d;
      units_q    <= units_d;
      len_left_q <= len_left_d;
      acc_q      <= acc_d;
      wide_q     <= wide_d;
      hi_q       <= hi_d;
      pend_q     <= pend_d;
      pend_v_q   <= pend_v_d;
      halted_q   <= halted_d;
      cnt_q      <= nres;
      rd_q       <= '0;
    end else if (m_xfer) begin
      cnt_q <= cnt_q - RES_W'(1);
      rd_q  <= rd_q + RES_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      for (int i = 0; i < RES_MAX; i++) buf_q[i] <= res_d[i];
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {5'b0, buf_q[rd_q].code, buf_q[rd_q].data};
  assign m_axis_tuser  = buf_q[rd_q].is_err;
  assign m_axis_tlast  = buf_q[rd_q].last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_W'(RES_MAX))
    else $error("result count out of range");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error result not last");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |-> (cnt_q == '0) || (cnt_q == RES_W'(1) && m_xfer))
    else $error("input taken while results pending");

  a_halt_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !(s_xfer && s_axis_tuser) |=> halted_q)
    else $error("halt released without first byte");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && m_axis_tlast |=> cnt_q <= RES_W'(RES_MAX) && (cnt_q == '0 || $past(s_xfer)))
    else $error("results remain after last transfer");

endmodule
